FILE: rtl/ofvg_pkg.sv
// Shared types and constants for the optical-flow velocity gate.
`timescale 1ns / 1ps
package ofvg_pkg;

    localparam int FLOW_W  = 24;
    localparam int TIME_W  = 24;
    localparam int DIST_W  = 16;
    localparam int SIGMA_W = 24;
    localparam int VEL_W   = 32;
    localparam int NOISE_W = 48;

    // |flow| * height, and the squared operand sigma * height
    localparam int PROD_W = 40;
    localparam int HALF_W = 20;
    // (|flow| * height * 1e6) >> 16 stays below 2^43
    localparam int NUM_W  = 43;
    // quotient bits developed by the divider; bit 31 and up means saturation
    localparam int QUO_W  = 31;
    localparam int SUM_W  = 60;
    localparam int SQ_W   = 62;

    localparam logic [HALF_W-1:0] US_PER_S      = 20'd1000000;
    localparam logic [DIST_W-1:0] MIN_HEIGHT_MM = 16'd100;
    localparam logic [VEL_W-1:0]  VEL_MAX       = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0]  VEL_MIN       = 32'h8000_0000;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA    = 4'd1;
    localparam logic [DIST_W-1:0]    FALLBACK_RST = 16'd1000;
    localparam logic [SIGMA_W-1:0]   SIGMA_RST    = 24'd65536;

    typedef struct packed {
        logic signed [FLOW_W-1:0] flow_x;
        logic signed [FLOW_W-1:0] flow_y;
        logic                     time_present;
        logic [TIME_W-1:0]        time_us;
        logic                     distance_present;
        logic [DIST_W-1:0]        distance_mm;
        logic                     sample_valid;
    } t_in_word;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity_x;
        logic signed [VEL_W-1:0] velocity_y;
        logic                    observation_ok;
        logic [NOISE_W-1:0]      noise_variance;
    } t_out_word;

    // control that rides beside the multiplier stages
    typedef struct packed {
        logic              ok;
        logic              neg_x;
        logic              neg_y;
        logic [TIME_W-1:0] t;
    } t_side;

    // one axis in the divider: partial remainder, numerator bits shifting
    // out at the top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [TIME_W-1:0] rem;
        logic [QUO_W-1:0]  nq;
        logic              sat;
        logic              neg;
    } t_div_lane;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic [TIME_W-1:0]  t;
        logic [NOISE_W-1:0] noise;
        t_div_lane          x;
        t_div_lane          y;
    } t_div_word;

endpackage

FILE: rtl/ofvg_axis_mul.sv
// Three-stage numerator path for one axis: (|flow| * height * 1e6) >> 16.
`timescale 1ns / 1ps
module ofvg_axis_mul (
    input  logic                          i_clk,
    input  logic [ofvg_pkg::FLOW_W-1:0]   i_mag,
    input  logic [ofvg_pkg::DIST_W-1:0]   i_h,
    output logic [ofvg_pkg::NUM_W-1:0]    o_num
);
    import ofvg_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_lo_mul;
    logic [PROD_W-1:0] r_hi_mul;
    logic [NUM_W-1:0]  r_num;
    logic [SUM_W-1:0]  n_sum;

    // recombine the split constant product, drop the Q16 fraction
    assign n_sum = {r_hi_mul, {HALF_W{1'b0}}} + SUM_W'(r_lo_mul);

    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(i_mag) * PROD_W'(i_h);
        r_lo_mul <= PROD_W'(r_prod[HALF_W-1:0]) * PROD_W'(US_PER_S);
        r_hi_mul <= PROD_W'(r_prod[PROD_W-1:HALF_W]) * PROD_W'(US_PER_S);
        r_num    <= n_sum[NUM_W+15:16];
    end

    assign o_num = r_num;

endmodule

FILE: rtl/ofvg_noise.sv
// Four-stage noise variance path: floor((sigma * height)^2 / 2^32).
`timescale 1ns / 1ps
module ofvg_noise (
    input  logic                           i_clk,
    input  logic [ofvg_pkg::SIGMA_W-1:0]   i_sigma,
    input  logic [ofvg_pkg::DIST_W-1:0]    i_hn,
    output logic [ofvg_pkg::NOISE_W-1:0]   o_noise
);
    import ofvg_pkg::*;

    logic [PROD_W-1:0]  r_p;
    logic [PROD_W-1:0]  r_hi2;
    logic [PROD_W-1:0]  r_hilo;
    logic [PROD_W-1:0]  r_lo2;
    logic [PROD_W-1:0]  r_hi2_d;
    logic [SQ_W-1:0]    r_low_sum;
    logic [NOISE_W-1:0] r_noise;

    always_ff @(posedge i_clk) begin
        r_p       <= PROD_W'(i_sigma) * PROD_W'(i_hn);
        // square as three half-width partial products
        r_hi2     <= PROD_W'(r_p[PROD_W-1:HALF_W]) * PROD_W'(r_p[PROD_W-1:HALF_W]);
        r_hilo    <= PROD_W'(r_p[PROD_W-1:HALF_W]) * PROD_W'(r_p[HALF_W-1:0]);
        r_lo2     <= PROD_W'(r_p[HALF_W-1:0]) * PROD_W'(r_p[HALF_W-1:0]);
        r_hi2_d   <= r_hi2;
        r_low_sum <= {r_hilo, 21'b0} + SQ_W'(r_lo2);
        r_noise   <= {r_hi2_d, 8'b0} + NOISE_W'(r_low_sum[SQ_W-1:32]);
    end

    assign o_noise = r_noise;

endmodule

FILE: rtl/ofvg_div_stage.sv
// One restoring-division step for both axes, one quotient bit per stage.
`timescale 1ns / 1ps
module ofvg_div_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ofvg_pkg::t_div_word   i_word,
    output ofvg_pkg::t_div_word   o_word
);
    import ofvg_pkg::*;

    t_div_word r_word;
    t_div_word n_word;
    logic      r_valid;

    function automatic t_div_lane div_step(input t_div_lane l, input logic [TIME_W-1:0] t);
        t_div_lane       res;
        logic [TIME_W:0] sh;
        logic [TIME_W+1:0] diff;
        logic            ge;
        sh   = {l.rem, l.nq[QUO_W-1]};
        diff = {1'b0, sh} - {2'b0, t};
        ge   = !diff[TIME_W+1];
        res      = l;
        res.rem  = ge ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
        res.nq   = {l.nq[QUO_W-2:0], ge};
        return res;
    endfunction

    always_comb begin
        n_word   = i_word;
        n_word.x = div_step(i_word.x, i_word.t);
        n_word.y = div_step(i_word.y, i_word.t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    always_comb begin
        o_word       = r_word;
        o_word.valid = r_valid;
    end

    // partial remainder of an unsaturated lane never reaches the divisor
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_word.ok && !r_word.x.sat |-> r_word.x.rem < r_word.t)
        else $error("x remainder not below divisor");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_word.ok && !r_word.y.sat |-> r_word.y.rem < r_word.t)
        else $error("y remainder not below divisor");

endmodule

FILE: rtl/optical_flow_velocity_gate_core.sv
// Top level of the optical-flow velocity gate: input stage, pipeline, result register.
`timescale 1ns / 1ps
// Fully pipelined: a sample word may be started on every clock, busy stays low,
// and each sample yields exactly one result word on o_out, flagged by a
// one-cycle o_strobe when it leaves the result register. The depth is set by
// the velocity divider, which develops one quotient bit per stage (31 stages)
// behind one input stage, three multiply stages and one saturation-check stage;
// the noise variance path runs beside it. The receiver cannot stall, so results
// must be taken the cycle they appear. Height is the sample's distance when one
// is present, else the fallback height register; fallback height and flow sigma
// are sampled when a word enters, so write them only while no samples are in
// flight. Velocities are zero whenever observation_ok is low.
module optical_flow_velocity_gate_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ofvg_pkg::t_in_word                i_in,
    output logic                              o_strobe,
    output ofvg_pkg::t_out_word               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ofvg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ofvg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ofvg_pkg::*;

    // ---------------- configuration registers ----------------
    logic [DIST_W-1:0]  r_fallback;
    logic [SIGMA_W-1:0] r_sigma;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback <= FALLBACK_RST;
            r_sigma    <= SIGMA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FALLBACK: r_fallback <= i_cfg_data[DIST_W-1:0];
                CFG_SIGMA:    r_sigma    <= i_cfg_data[SIGMA_W-1:0];
                default:      ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------- stage 1: capture and classify ----------------
    assign busy = 1'b0;

    logic              n_accept;
    logic [DIST_W-1:0] n_h;
    logic [DIST_W-1:0] n_hn;
    logic              n_neg_x;
    logic              n_neg_y;
    logic [FLOW_W-1:0] n_mag_x;
    logic [FLOW_W-1:0] n_mag_y;
    t_side             n_side;

    // valid bits for stages 1..5
    logic [4:0]         r_vld;
    t_side              r_s1_side;
    t_side              r_s2_side;
    t_side              r_s3_side;
    t_side              r_s4_side;
    logic [FLOW_W-1:0]  r_s1_mag_x;
    logic [FLOW_W-1:0]  r_s1_mag_y;
    logic [DIST_W-1:0]  r_s1_h;
    logic [DIST_W-1:0]  r_s1_hn;
    logic [SIGMA_W-1:0] r_s1_sigma;

    always_comb begin
        n_accept = start && !busy;
        n_h      = i_in.distance_present ? i_in.distance_mm : r_fallback;
        n_hn     = (n_h < MIN_HEIGHT_MM) ? MIN_HEIGHT_MM : n_h;
        n_neg_x  = i_in.flow_x[FLOW_W-1];
        n_neg_y  = i_in.flow_y[FLOW_W-1];
        // magnitude of the most negative flow still fits as unsigned
        n_mag_x  = n_neg_x ? (~i_in.flow_x + 1'b1) : i_in.flow_x;
        n_mag_y  = n_neg_y ? (~i_in.flow_y + 1'b1) : i_in.flow_y;
        n_side.ok    = i_in.sample_valid && i_in.time_present &&
                       (i_in.time_us != '0) && (n_h >= MIN_HEIGHT_MM);
        n_side.neg_x = n_neg_x;
        n_side.neg_y = n_neg_y;
        n_side.t     = i_in.time_us;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], n_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_side  <= n_side;
        r_s1_mag_x <= n_mag_x;
        r_s1_mag_y <= n_mag_y;
        r_s1_h     <= n_h;
        r_s1_hn    <= n_hn;
        r_s1_sigma <= r_sigma;
        // side band follows the three multiply stages
        r_s2_side  <= r_s1_side;
        r_s3_side  <= r_s2_side;
        r_s4_side  <= r_s3_side;
    end

    // ---------------- stages 2..4: numerators, stages 2..5: noise ----------------
    logic [NUM_W-1:0]   w_num_x;
    logic [NUM_W-1:0]   w_num_y;
    logic [NOISE_W-1:0] w_noise;

    ofvg_axis_mul u_mul_x (
        .i_clk (i_clk),
        .i_mag (r_s1_mag_x),
        .i_h   (r_s1_h),
        .o_num (w_num_x)
    );

    ofvg_axis_mul u_mul_y (
        .i_clk (i_clk),
        .i_mag (r_s1_mag_y),
        .i_h   (r_s1_h),
        .o_num (w_num_y)
    );

    ofvg_noise u_noise (
        .i_clk   (i_clk),
        .i_sigma (r_s1_sigma),
        .i_hn    (r_s1_hn),
        .o_noise (w_noise)
    );

    // ---------------- stage 5: saturation check, divider seed ----------------
    // quotient >= 2^31 exactly when num >> 31 >= time; such lanes saturate
    // and their divider run is a don't-care
    function automatic t_div_lane seed_lane(input logic [NUM_W-1:0] num,
                                            input logic [TIME_W-1:0] t,
                                            input logic neg);
        t_div_lane l;
        logic      sat;
        sat   = TIME_W'(num[NUM_W-1:QUO_W]) >= t;
        l.sat = sat;
        l.neg = neg;
        l.rem = sat ? '0 : TIME_W'(num[NUM_W-1:QUO_W]);
        l.nq  = num[QUO_W-1:0];
        return l;
    endfunction

    logic              r_s5_ok;
    logic [TIME_W-1:0] r_s5_t;
    t_div_lane         r_s5_x;
    t_div_lane         r_s5_y;

    always_ff @(posedge i_clk) begin
        r_s5_ok <= r_s4_side.ok;
        r_s5_t  <= r_s4_side.t;
        r_s5_x  <= seed_lane(w_num_x, r_s4_side.t, r_s4_side.neg_x);
        r_s5_y  <= seed_lane(w_num_y, r_s4_side.t, r_s4_side.neg_y);
    end

    // ---------------- stages 6..36: divider ----------------
    t_div_word w_div [0:QUO_W];

    always_comb begin
        w_div[0].valid = r_vld[4];
        w_div[0].ok    = r_s5_ok;
        w_div[0].t     = r_s5_t;
        w_div[0].noise = w_noise;
        w_div[0].x     = r_s5_x;
        w_div[0].y     = r_s5_y;
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        ofvg_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_div[g]),
            .o_word  (w_div[g+1])
        );
    end

    // ---------------- result register ----------------
    function automatic logic [VEL_W-1:0] lane_velocity(input t_div_lane l);
        logic [VEL_W-1:0] mag;
        mag = {1'b0, l.nq};
        if (l.sat) begin
            return l.neg ? VEL_MIN : VEL_MAX;
        end
        return l.neg ? (~mag + 1'b1) : mag;
    endfunction

    t_div_word  w_last;
    t_out_word  n_out;
    t_out_word  r_out;
    logic       r_strobe;

    assign w_last = w_div[QUO_W];

    always_comb begin
        n_out.observation_ok = w_last.ok;
        n_out.noise_variance = w_last.noise;
        // rejected samples report zero velocity
        n_out.velocity_x = w_last.ok ? $signed(lane_velocity(w_last.x)) : '0;
        n_out.velocity_y = w_last.ok ? $signed(lane_velocity(w_last.y)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // an accepted observation always has a nonzero divisor
    a_ok_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && r_s5_ok |-> r_s5_t != '0)
        else $error("accepted observation with zero integration time");

    // a rejected result carries no velocity
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_out.observation_ok |->
            o_out.velocity_x == '0 && o_out.velocity_y == '0)
        else $error("rejected result with nonzero velocity");

    // a positive x lane cannot produce a negative velocity
    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid && w_last.ok && !w_last.x.neg |=> !o_out.velocity_x[VEL_W-1])
        else $error("positive flow gave negative x velocity");

endmodule

FILE: tb/ofvg_checker.sv
// Checker for the optical-flow velocity gate: predicts each result word and compares it.
`timescale 1ns / 1ps
module ofvg_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  ofvg_pkg::t_in_word              i_in,
    input  logic                            i_strobe,
    input  ofvg_pkg::t_out_word             i_out,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ofvg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ofvg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    import ofvg_pkg::*;

    logic [DIST_W-1:0]  fallback_mm;
    logic [SIGMA_W-1:0] sigma_q16;
    t_out_word          velocity_q[$];

    // Truncate toward zero, saturate to 32 bits.
    function automatic logic [VEL_W-1:0] axis_speed(logic [FLOW_W-1:0] flow,
                                                    logic [DIST_W-1:0] h,
                                                    logic [TIME_W-1:0] t);
        logic [FLOW_W:0] mag;
        logic [63:0]     num;
        logic [63:0]     quo;
        mag = flow[FLOW_W-1] ? (25'h100_0000 - {1'b0, flow}) : {1'b0, flow};
        num = 64'(mag) * 64'(h) * 64'(US_PER_S);
        quo = num / (64'(t) << 16);
        if (flow[FLOW_W-1]) begin
            if (quo >= 64'h8000_0000)
                return VEL_MIN;
            return -quo[VEL_W-1:0];
        end
        if (quo > 64'h7FFF_FFFF)
            return VEL_MAX;
        return quo[VEL_W-1:0];
    endfunction

    function automatic t_out_word gate_sample(t_in_word s);
        t_out_word         r;
        logic [DIST_W-1:0] h;
        logic [DIST_W-1:0] hn;
        logic [39:0]       p;
        logic [79:0]       sq;
        h  = s.distance_present ? s.distance_mm : fallback_mm;
        hn = (h < MIN_HEIGHT_MM) ? MIN_HEIGHT_MM : h;
        r  = '0;
        r.observation_ok = s.sample_valid && s.time_present && (s.time_us != '0)
                           && (h >= MIN_HEIGHT_MM);
        if (r.observation_ok) begin
            r.velocity_x = axis_speed(s.flow_x, h, s.time_us);
            r.velocity_y = axis_speed(s.flow_y, h, s.time_us);
        end
        p  = 40'(sigma_q16) * 40'(hn);
        sq = {40'd0, p} * {40'd0, p};
        sq = sq >> 32;
        r.noise_variance = (sq > 80'hFFFF_FFFF_FFFF) ? '1 : sq[NOISE_W-1:0];
        return r;
    endfunction

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            fallback_mm = FALLBACK_RST;
            sigma_q16   = SIGMA_RST;
            velocity_q.delete();
        end else begin
            // unknown indexes fall through untouched
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FALLBACK)
                    fallback_mm = i_cfg_data[DIST_W-1:0];
                else if (i_cfg_index == CFG_SIGMA)
                    sigma_q16 = i_cfg_data[SIGMA_W-1:0];
            end
            if (i_start && !i_busy)
                velocity_q.push_back(gate_sample(i_in));
            if (i_strobe) begin
                if (velocity_q.size() == 0) begin
                    $display("%0t: result word expected none, got %0h", $time, i_out);
                    o_errors++;
                end else begin
                    want = velocity_q.pop_front();
                    report_field("velocity_x", 64'(want.velocity_x), 64'(i_out.velocity_x));
                    report_field("velocity_y", 64'(want.velocity_y), 64'(i_out.velocity_y));
                    report_field("observation_ok", 64'(want.observation_ok),
                                 64'(i_out.observation_ok));
                    report_field("noise_variance", 64'(want.noise_variance),
                                 64'(i_out.noise_variance));
                end
            end
        end
        o_pending <= velocity_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Testbench top for the optical-flow velocity gate: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
    import ofvg_pkg::*;

    // Idle time after the final drain: covers the pipeline depth with margin on top.
    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 5;
    localparam int PHASE_WORDS  = 108;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_word              i_in;
    logic                  o_strobe;
    t_out_word             o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;

    optical_flow_velocity_gate_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ofvg_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_in        (i_in),
        .i_strobe    (o_strobe),
        .i_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Present one sample word and hold it until the edge that takes it.
    // Leave start high afterwards so back-to-back words need no re-raise.
    task automatic send_sample(input t_in_word s);
        i_in  <= s;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for a burst of idle cycles.
    task automatic idle_input(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop issuing and wait until every expected result word has come back.
    // The checker counts the last accepted word before pending is first read.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write one register, then release the channel so that a
    // following write starts on a later edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_word make_sample(logic [FLOW_W-1:0] fx, logic [FLOW_W-1:0] fy,
                                             logic tp, logic [TIME_W-1:0] t,
                                             logic dp, logic [DIST_W-1:0] d,
                                             logic v);
        t_in_word s;
        s.flow_x           = fx;
        s.flow_y           = fy;
        s.time_present     = tp;
        s.time_us          = t;
        s.distance_present = dp;
        s.distance_mm      = d;
        s.sample_valid     = v;
        return s;
    endfunction

    // Mostly well-formed samples with random content, near the height floor
    // and at short times often enough to hit saturation; the rest is raw noise.
    function automatic t_in_word random_sample();
        t_in_word     s;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        s   = raw[$bits(t_in_word)-1:0];
        if ($urandom_range(0, 9) < 8) begin
            s.sample_valid = 1'b1;
            s.time_present = 1'b1;
            case ($urandom_range(0, 2))
                0: s.time_us = TIME_W'($urandom_range(1, 255));
                1: s.time_us = TIME_W'($urandom_range(1000, 100000));
                default: s.time_us = TIME_W'($urandom_range(1, 24'hFF_FFFF));
            endcase
            s.distance_present = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: s.distance_mm = DIST_W'($urandom_range(90, 110));
                1: s.distance_mm = DIST_W'($urandom_range(100, 5000));
                default: s.distance_mm = DIST_W'($urandom);
            endcase
            if ($urandom_range(0, 1) == 0) begin
                s.flow_x = {{8{raw[15]}}, raw[15:0]};
                s.flow_y = {{8{raw[31]}}, raw[31:16]};
            end
        end
        return s;
    endfunction

    // Watchdog: end the run if the drain never completes.
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int idle_odds;
        int phase_fallback;
        int phase_sigma;
        start       <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset register values.
        // Both axes saturate: largest flows, shortest time, tallest height.
        send_sample(make_sample(24'h7F_FFFF, 24'h80_0000, 1'b1, 24'd1, 1'b1, 16'hFFFF, 1'b1));
        // Height exactly at the floor, longest time, zero flow.
        send_sample(make_sample(24'h00_0000, 24'h00_0000, 1'b1, 24'hFF_FFFF, 1'b1, 16'd100,
                                1'b1));
        // Height just below the floor, then zero height: rejected.
        send_sample(make_sample(24'h01_0000, 24'hFF_0000, 1'b1, 24'd1000, 1'b1, 16'd99, 1'b1));
        send_sample(make_sample(24'h01_0000, 24'hFF_0000, 1'b1, 24'd1000, 1'b1, 16'd0, 1'b1));
        // Sample flagged invalid.
        send_sample(make_sample(24'h01_0000, 24'h02_0000, 1'b1, 24'd1000, 1'b1, 16'd500, 1'b0));
        // Time carried but marked absent, then present with zero time.
        send_sample(make_sample(24'h01_0000, 24'h02_0000, 1'b0, 24'd1000, 1'b1, 16'd500, 1'b1));
        send_sample(make_sample(24'h01_0000, 24'h02_0000, 1'b1, 24'd0, 1'b1, 16'd500, 1'b1));
        // Distance carried but marked absent: fallback height wins.
        send_sample(make_sample(24'h01_0000, 24'hFE_8000, 1'b1, 24'd20000, 1'b0, 16'd50, 1'b1));
        // Tiny flows over a long time truncate toward zero on both signs; then unit flows of opposite sign.
        send_sample(make_sample(24'hFF_FFFF, 24'h00_0001, 1'b1, 24'hFF_FFFF, 1'b1, 16'd100,
                                1'b1));
        send_sample(make_sample(24'h01_0000, 24'hFF_0000, 1'b1, 24'd10000, 1'b1, 16'd1000,
                                1'b1));
        // Every input bit high.
        send_sample(make_sample(24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 24'hFF_FFFF, 1'b1, 16'hFFFF,
                                1'b1));
        drain_results();

        // Fallback zero, written with junk in the unused upper data bits.
        write_reg(CFG_FALLBACK, 24'hAB_0000);
        send_sample(make_sample(24'h01_0000, 24'h01_0000, 1'b1, 24'd1000, 1'b0, 16'd500, 1'b1));
        send_sample(make_sample(24'h01_0000, 24'h01_0000, 1'b1, 24'd1000, 1'b1, 16'd100, 1'b1));
        drain_results();

        // Fallback one below the floor, largest sigma.
        write_reg(CFG_FALLBACK, 24'h00_0063);
        write_reg(CFG_SIGMA, 24'hFF_FFFF);
        send_sample(make_sample(24'h12_3456, 24'hED_CBA9, 1'b1, 24'd777, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(24'h12_3456, 24'hED_CBA9, 1'b1, 24'd777, 1'b1, 16'hFFFF, 1'b1));
        drain_results();

        // Fallback at the floor, sigma zero; writes to unknown indexes must not land.
        write_reg(CFG_FALLBACK, 24'h00_0064);
        write_reg(CFG_SIGMA, 24'h00_0000);
        write_reg(CFG_IDX_W'(2), 24'h00_0001);
        write_reg(CFG_IDX_W'(15), 24'hFF_FFFF);
        send_sample(make_sample(24'h7F_FFFF, 24'h80_0000, 1'b1, 24'd1, 1'b0, 16'd0, 1'b1));
        send_sample(make_sample(24'h40_0000, 24'hC0_0000, 1'b1, 24'd65536, 1'b0, 16'd7, 1'b1));
        drain_results();

        // Random phases, each under its own register settings; extremes come first.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    phase_fallback = 16'hFFFF;
                    phase_sigma    = 24'hFF_FFFF;
                end
                1: begin
                    phase_fallback = 0;
                    phase_sigma    = 0;
                end
                default: begin
                    phase_fallback = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                                                 : $urandom_range(0, 16'hFFFF);
                    phase_sigma    = $urandom_range(0, 24'hFF_FFFF);
                end
            endcase
            // Upper data bits on the fallback write are random and must be dropped.
            write_reg(CFG_FALLBACK, {8'($urandom), 16'(phase_fallback)});
            write_reg(CFG_SIGMA, CFG_DATA_W'(phase_sigma));
            write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));

            // Vary how often the sender goes quiet; the last phase runs flat out.
            idle_odds = (ph == PHASES - 1) ? 0 : ((ph % 2 == 0) ? 3 : 8);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_sample(random_sample());
                if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
                    idle_input($urandom_range(1, 11));
            end
            drain_results();
        end

        // Let any stray late word show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
